[sv/lztd_pkg.sv]
// shared types and constants of the lzss text decompressor
// no dependencies; imported by lztd_seq, lztd_window, lztd_rdchk and the top level
`default_nettype none

package lztd_pkg;

  // parse phases, two bits wide; the fourth code parses as a header
  typedef logic [1:0] phase_t;
  localparam phase_t PH_HEADER  = 2'd0;
  localparam phase_t PH_LITERAL = 2'd1;
  localparam phase_t PH_LONG2   = 2'd2;

  // header codes
  localparam logic [7:0] END_CODE = 8'h00;
  localparam logic [7:0] LIT_MASK = 8'hFC;
  localparam logic [7:0] LIT_CODE = 8'h7C;

  // widths of the copy distance (plus length) and of the copy length
  localparam int BACK_W = 12;
  localparam int LEN_W  = 5;

  // window port controls driven by the sequencer
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] wr_data;
  } win_ctl_t;

endpackage

`default_nettype wire

[sv/lzss_text_decompressor_top.sv]
// top level of the lzss text decompressor
// depends on lztd_pkg, lztd_window, lztd_rdchk and lztd_seq
//
//   channel  | ports                        | moves
//   ---------+------------------------------+----------------------------
//   input    | in_valid in_stall in_byte    | one compressed byte an item
//   output   | out_valid out_stall out_byte | one decompressed byte an item
//
// copies: each copied byte of a copy token takes a read and then a write
//   of the single-port window memory
// reset: synchronous, active low; no clearing pass, a fill counter makes
//   never-written window slots read as zero
// stalls: the output register holds a byte under out_stall while the next
//   input item is still taken; the sequencer waits only when it must emit
`default_nettype none

module lzss_text_decompressor_top #(
  parameter int WINDOW_SIZE = 4096
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte
);
  import lztd_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);

  win_ctl_t      win_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;

  lztd_seq #(.AW(AW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .win_ctl   (win_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .rd_data   (rd_data)
  );

  lztd_window #(.AW(AW)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_ctl (win_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd_data (rd_data)
  );

  lztd_rdchk #(.AW(AW)) u_rdchk (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_ctl (win_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

endmodule

`default_nettype wire

[sv/lztd_window.sv]
// history window: one synchronous byte memory with registered read data
// depends on lztd_pkg; a fill counter stands in for clearing the memory
`default_nettype none

module lztd_window #(
  parameter int AW = 12
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  lztd_pkg::win_ctl_t    win_ctl,
  input  wire  [AW-1:0]         rd_addr,
  input  wire  [AW-1:0]         wr_addr,
  output logic [7:0]            rd_data
);
  import lztd_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q_r;
  logic          rd_zero_r;
  logic [AW-1:0] fill_r;
  logic          full_r;

  // writes run in address order from zero, so an entry below the fill
  // count, or any entry once the window wrapped, holds written data
  always_ff @(posedge clk) begin
    if (win_ctl.wr_en) begin
      mem[wr_addr] <= win_ctl.wr_data;
    end
    if (win_ctl.rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_zero_r <= !full_r && (rd_addr >= fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      full_r <= 1'b0;
    end else if (win_ctl.wr_en && !full_r) begin
      fill_r <= fill_r + 1'b1;
      if (fill_r == {AW{1'b1}}) begin
        full_r <= 1'b1;
      end
    end
  end

  assign rd_data = rd_zero_r ? 8'h00 : mem_q_r;

endmodule

`default_nettype wire

[sv/lztd_seq.sv]
// token parser and copy sequencer with the output register
// depends on lztd_pkg; drives the ports of lztd_window
`default_nettype none

module lztd_seq #(
  parameter int AW = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [7:0]          in_byte,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_byte,
  output lztd_pkg::win_ctl_t  win_ctl,
  output logic [AW-1:0]       rd_addr,
  output logic [AW-1:0]       wr_addr,
  input  wire  [7:0]          rd_data
);
  import lztd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LIT, S_COPY_RD, S_COPY_WR} state_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [2:0]          lit_r, lit_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                ended_r, ended_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [BACK_W-1:0]   back_r, back_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_free;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    lit_nxt       = lit_r;
    held_nxt      = held_r;
    ended_nxt     = ended_r;
    wp_nxt        = wp_r;
    back_nxt      = back_r;
    len_nxt       = len_r;
    byte_nxt      = byte_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_free      = !out_valid_r || !out_stall;
    win_ctl.rd_en   = 1'b0;
    win_ctl.wr_en   = 1'b0;
    win_ctl.wr_data = (state_r == S_LIT) ? byte_r : rd_data;
    rd_addr       = wp_r - AW'(back_r);
    wr_addr       = wp_r;
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid && !ended_r) begin
          case (phase_r)
            PH_LITERAL: begin
              byte_nxt  = in_byte;
              lit_nxt   = lit_r - 3'd1;
              if (lit_r == 3'd1) begin
                phase_nxt = PH_HEADER;
              end
              state_nxt = S_LIT;
            end
            PH_LONG2: begin
              back_nxt  = {1'b0, held_r[6:0], in_byte[7:4]}
                          + BACK_W'(in_byte[3:0]) + BACK_W'(1);
              len_nxt   = LEN_W'(in_byte[3:0]) + LEN_W'(1);
              phase_nxt = PH_HEADER;
              state_nxt = S_COPY_RD;
            end
            default: begin
              phase_nxt = PH_HEADER;
              if (in_byte == END_CODE) begin
                ended_nxt = 1'b1;
              end else if ((in_byte & LIT_MASK) == LIT_CODE) begin
                lit_nxt   = 3'(in_byte[1:0]) + 3'd1;
                phase_nxt = PH_LITERAL;
              end else if (!in_byte[7]) begin
                back_nxt  = BACK_W'(in_byte[6:2]) + BACK_W'(in_byte[1:0])
                            + BACK_W'(1);
                len_nxt   = LEN_W'(in_byte[1:0]) + LEN_W'(1);
                state_nxt = S_COPY_RD;
              end else begin
                held_nxt  = in_byte;
                phase_nxt = PH_LONG2;
              end
            end
          endcase
        end
      end
      S_LIT: begin
        if (out_free) begin
          win_ctl.wr_en = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          wp_nxt        = wp_r + 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_COPY_RD: begin
        // read issued in a later cycle than the previous write, so no bypass needed
        win_ctl.rd_en = 1'b1;
        state_nxt     = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (out_free) begin
          win_ctl.wr_en = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          wp_nxt        = wp_r + 1'b1;
          len_nxt       = len_r - 1'b1;
          state_nxt     = (len_r == LEN_W'(1)) ? S_IDLE : S_COPY_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      lit_r       <= '0;
      held_r      <= '0;
      ended_r     <= 1'b0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      lit_r       <= lit_nxt;
      held_r      <= held_nxt;
      ended_r     <= ended_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    back_r     <= back_nxt;
    len_r      <= len_nxt;
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  a_wr_shows_item: assert property (@(posedge clk) disable iff (!rst_n)
    win_ctl.wr_en |=> out_valid_r)
    else $error("window write without an output item");

  a_ended_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> !win_ctl.wr_en && !win_ctl.rd_en && (state_r == S_IDLE))
    else $error("window access after end of stream");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_RD) |-> (len_r != '0) && (back_r != '0))
    else $error("copy with zero length or distance");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    win_ctl.rd_en |=> (state_r == S_COPY_WR))
    else $error("window read not followed by copy write");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    win_ctl.wr_en |=> (wp_r == $past(wp_r) + 1'b1))
    else $error("write pointer did not advance");

endmodule

`default_nettype wire

[sv/lztd_window_top_dummy_placeholder.sv]
// window address helper: registers nothing, checks window reads stay ordered
// depends on lztd_pkg; not instantiated elsewhere than the top level
`default_nettype none

module lztd_rdchk #(
  parameter int AW = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lztd_pkg::win_ctl_t  win_ctl,
  input  wire  [AW-1:0]       rd_addr,
  input  wire  [AW-1:0]       wr_addr
);
  import lztd_pkg::*;

  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(win_ctl.rd_en && win_ctl.wr_en))
    else $error("window read and write in one cycle");

  a_rd_not_wr_slot: assert property (@(posedge clk) disable iff (!rst_n)
    win_ctl.rd_en |-> (rd_addr != wr_addr))
    else $error("copy reads the slot about to be written");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    win_ctl.wr_en && $past(win_ctl.rd_en) |-> (wr_addr == $past(wr_addr)))
    else $error("write slot moved between read and write");

endmodule

`default_nettype wire
